>>> rtl/crkd_pkg.sv
// Package for the chord release keycode decoder: chord constants, HID code ROMs,
// per-hand decode result type and the per-hand decode function.
// No dependencies.
`timescale 1ns / 1ps

package crkd_pkg;

  localparam int unsigned ChordW = 5;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned CountW = 3;

  // special chords
  localparam logic [ChordW-1:0] NAV_CHORD  = 5'h01;
  localparam logic [ChordW-1:0] NUM_CHORD  = 5'h10;
  // ROM slot used when the other group of the chord is empty
  localparam logic [ChordW-1:0] EMPTY_SLOT = 5'd15;

  localparam logic [KeyW-1:0] SHIFT_BITS  = 8'h22;
  localparam logic [KeyW-1:0] LSHIFT_BIT  = 8'h02;
  localparam logic [KeyW-1:0] MOD_CODE_LO = 8'hE0;

  // HID usage codes that get special handling
  localparam logic [KeyW-1:0] KP_DOT    = 8'h63;
  localparam logic [KeyW-1:0] KP_MINUS  = 8'h56;
  localparam logic [KeyW-1:0] KP_SLASH  = 8'h54;
  localparam logic [KeyW-1:0] KP_PLUS   = 8'h57;
  localparam logic [KeyW-1:0] KP_STAR   = 8'h55;
  localparam logic [KeyW-1:0] KEY_DOT   = 8'h37;
  localparam logic [KeyW-1:0] KEY_MINUS = 8'h2D;
  localparam logic [KeyW-1:0] KEY_SLASH = 8'h38;
  localparam logic [KeyW-1:0] KEY_EQUAL = 8'h2E;
  localparam logic [KeyW-1:0] KEY_8     = 8'h25;
  localparam logic [KeyW-1:0] ARROW_RT  = 8'h4F;
  localparam logic [KeyW-1:0] ARROW_LT  = 8'h50;
  localparam logic [KeyW-1:0] ARROW_DN  = 8'h51;
  localparam logic [KeyW-1:0] ARROW_UP  = 8'h52;

  // decode result of one hand for one scan
  typedef struct packed {
    logic [1:0][KeyW-1:0] keys;      // unused entries are zero
    logic [1:0]           count;     // 0..2
    logic [KeyW-1:0]      mods;
    logic                 set_shift;
    logic                 clr_shift;
    logic                 growing;   // next value of the growing flag
    logic                 up_first;  // next value of the up-first flag
  } hand_res_t;

  // letter layer, indexed by chord - 1
  function automatic logic [KeyW-1:0] rom_letters(input logic [ChordW-1:0] idx);
    logic [KeyW-1:0] k;
    unique case (idx)
      5'd0:  k = 8'h00;  5'd1:  k = 8'h12;  5'd2:  k = 8'h04;  5'd3:  k = 8'h2C;
      5'd4:  k = 8'h11;  5'd5:  k = 8'h16;  5'd6:  k = 8'h0F;  5'd7:  k = 8'h08;
      5'd8:  k = 8'h0C;  5'd9:  k = 8'h07;  5'd10: k = 8'h13;  5'd11: k = 8'h17;
      5'd12: k = 8'h15;  5'd13: k = 8'h0B;  5'd14: k = 8'h18;  5'd15: k = 8'h00;
      5'd16: k = 8'h00;  5'd17: k = 8'h1A;  5'd18: k = 8'h0D;  5'd19: k = 8'h19;
      5'd20: k = 8'h05;  5'd21: k = 8'h0E;  5'd22: k = 8'h14;  5'd23: k = 8'h06;
      5'd24: k = 8'h10;  5'd25: k = 8'h1B;  5'd26: k = 8'h1D;  5'd27: k = 8'h09;
      5'd28: k = 8'h0A;  5'd29: k = 8'h1C;  5'd30: k = 8'hE1;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // number / symbol layer
  function automatic logic [KeyW-1:0] rom_num1(input logic [ChordW-1:0] idx);
    logic [KeyW-1:0] k;
    unique case (idx)
      5'd0:  k = 8'h1E;  5'd1:  k = 8'h1F;  5'd2:  k = 8'h20;  5'd3:  k = 8'h21;
      5'd4:  k = 8'h22;  5'd5:  k = 8'h23;  5'd6:  k = 8'h24;  5'd7:  k = 8'h25;
      5'd8:  k = 8'h26;  5'd9:  k = 8'h27;  5'd10: k = 8'h63;  5'd11: k = 8'h56;
      5'd12: k = 8'h54;  5'd13: k = 8'h57;  5'd14: k = 8'h55;  5'd15: k = 8'h58;
      5'd16: k = 8'h3A;  5'd17: k = 8'h3B;  5'd18: k = 8'h3C;  5'd19: k = 8'h3D;
      5'd20: k = 8'h3E;  5'd21: k = 8'h3F;  5'd22: k = 8'h40;  5'd23: k = 8'h41;
      5'd24: k = 8'h42;  5'd25: k = 8'h43;  5'd26: k = 8'h44;  5'd27: k = 8'h45;
      5'd28: k = 8'h53;  5'd29: k = 8'h47;  5'd30: k = 8'h39;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // keypad / function layer
  function automatic logic [KeyW-1:0] rom_num2(input logic [ChordW-1:0] idx);
    logic [KeyW-1:0] k;
    unique case (idx)
      5'd0:  k = 8'h59;  5'd1:  k = 8'h5A;  5'd2:  k = 8'h5B;  5'd3:  k = 8'h5C;
      5'd4:  k = 8'h5D;  5'd5:  k = 8'h5E;  5'd6:  k = 8'h5F;  5'd7:  k = 8'h60;
      5'd8:  k = 8'h61;  5'd9:  k = 8'h62;  5'd10: k = 8'h63;  5'd11: k = 8'h56;
      5'd12: k = 8'h54;  5'd13: k = 8'h57;  5'd14: k = 8'h55;  5'd15: k = 8'h2A;
      5'd16: k = 8'h3A;  5'd17: k = 8'h3B;  5'd18: k = 8'h3C;  5'd19: k = 8'h3D;
      5'd20: k = 8'h3E;  5'd21: k = 8'h3F;  5'd22: k = 8'h40;  5'd23: k = 8'h41;
      5'd24: k = 8'h42;  5'd25: k = 8'h43;  5'd26: k = 8'h44;  5'd27: k = 8'h45;
      5'd28: k = 8'h53;  5'd29: k = 8'h47;  5'd30: k = 8'h39;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // navigation layer; codes E0..E7 are modifiers
  function automatic logic [KeyW-1:0] rom_nav(input logic [ChordW-1:0] idx);
    logic [KeyW-1:0] k;
    unique case (idx)
      5'd0:  k = 8'h29;  5'd1:  k = 8'h4F;  5'd2:  k = 8'h14;  5'd3:  k = 8'h51;
      5'd4:  k = 8'h37;  5'd5:  k = 8'h4D;  5'd6:  k = 8'h48;  5'd7:  k = 8'h52;
      5'd8:  k = 8'h0C;  5'd9:  k = 8'h2A;  5'd10: k = 8'h04;  5'd11: k = 8'h4E;
      5'd12: k = 8'h2B;  5'd13: k = 8'hE0;  5'd14: k = 8'hE4;  5'd15: k = 8'h50;
      5'd16: k = 8'h34;  5'd17: k = 8'h4B;  5'd18: k = 8'h1A;  5'd19: k = 8'h4C;
      5'd20: k = 8'h49;  5'd21: k = 8'hE3;  5'd22: k = 8'hE7;  5'd23: k = 8'h4A;
      5'd24: k = 8'h46;  5'd25: k = 8'h2C;  5'd26: k = 8'h27;  5'd27: k = 8'hE2;
      5'd28: k = 8'hE6;  5'd29: k = 8'hE1;  5'd30: k = 8'hE5;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // Release detection, flag update and layer decode for one hand.
  function automatic hand_res_t hand_decode(
    input logic [ChordW-1:0] pa,
    input logic [ChordW-1:0] pb,
    input logic [ChordW-1:0] ca,
    input logic [ChordW-1:0] cb,
    input logic              growing,
    input logic              up_first,
    input logic              side
  );
    hand_res_t       r;
    logic [KeyW-1:0] k;
    r          = '0;
    r.growing  = growing;
    r.up_first = up_first;
    k          = '0;
    if ((ca < pa) || (cb < pb)) begin
      if (growing) begin
        r.growing = 1'b0;
        if ((pb == NUM_CHORD) && ((pa != NAV_CHORD) || up_first)) begin
          k = (pa != '0) ? rom_num1(pa - 5'd1) : rom_num1(EMPTY_SLOT);
          // keypad symbols map onto main-row keys with a forced shift state
          case (k)
            KP_DOT:   begin k = KEY_DOT;   r.clr_shift = 1'b1; end
            KP_MINUS: begin k = KEY_MINUS; r.clr_shift = 1'b1; end
            KP_SLASH: begin k = KEY_SLASH; r.clr_shift = 1'b1; end
            KP_PLUS:  begin k = KEY_EQUAL; r.set_shift = 1'b1; end
            KP_STAR:  begin k = KEY_8;     r.set_shift = 1'b1; end
            default:  ;
          endcase
          r.keys[0] = k;
          r.count   = 2'd1;
        end else if (pa == NUM_CHORD) begin
          r.keys[0] = (pb != '0) ? rom_num2(pb - 5'd1) : rom_num2(EMPTY_SLOT);
          r.count   = 2'd1;
        end else if (pb == NAV_CHORD) begin
          // mouse chord: no key
        end else if (pa == NAV_CHORD) begin
          if (pb != '0) begin
            k = rom_nav(pb - 5'd1);
            if (k >= MOD_CODE_LO) begin
              r.mods = 8'd1 << k[2:0];
            end else begin
              // second hand mirrors the arrows
              if (side) begin
                case (k)
                  ARROW_RT: k = ARROW_LT;
                  ARROW_LT: k = ARROW_RT;
                  ARROW_DN: k = ARROW_UP;
                  ARROW_UP: k = ARROW_DN;
                  default:  ;
                endcase
              end
              r.keys[0] = k;
              r.count   = 2'd1;
            end
          end
        end else begin
          // letters: first group, then second group
          if (pa != '0) begin
            r.keys[0] = rom_letters(pa - 5'd1);
          end
          if (pb != '0) begin
            if (pa != '0) begin
              r.keys[1] = rom_letters(pb - 5'd1);
            end else begin
              r.keys[0] = rom_letters(pb - 5'd1);
            end
          end
          r.count = 2'({1'b0, pa != '0}) + 2'({1'b0, pb != '0});
        end
      end
    end else if ((ca > pa) || (cb > pb)) begin
      r.growing = 1'b1;
      if (pb != '0) begin
        r.up_first = 1'b1;
      end else if (pa != '0) begin
        r.up_first = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/chord_release_keycode_decoder_core.sv
// Chord release keycode decoder, top level.
// The report word for an accepted scan word is registered and valid in the next cycle.
// Throughput: one scan word per cycle; a held report blocks input until it is taken.
// Per-hand decode is one pass of compares and small ROM lookups.
// Reset (rst_ni low, async): previous chords cleared, flags set, no report pending.
// Depends on crkd_pkg.
`timescale 1ns / 1ps

module chord_release_keycode_decoder_core
  import crkd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // scan words in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // side0_first, side0_second, side1_first, side1_second
  // report words out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // modifier_bits, key_a, key_b, key_c, key_d, key_count
);

  logic [3:0][ChordW-1:0] prev_q, prev_d;
  logic [1:0]             growing_q, growing_d;
  logic [1:0]             up_first_q, up_first_d;
  logic                   out_valid_q, out_valid_d;
  logic [KeyW-1:0]        mods_q, mods_d;
  logic [3:0][KeyW-1:0]   keys_q, keys_d;
  logic [CountW-1:0]      count_q, count_d;

  logic [3:0][ChordW-1:0] cur;
  hand_res_t              h0, h1;
  logic                   in_acc;
  logic [KeyW-1:0]        mods_or, mods_clr;

  // input handshake: a held report only blocks when it is not being taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // unpack scan word
  assign cur[0] = s_axis_tdata[4:0];
  assign cur[1] = s_axis_tdata[9:5];
  assign cur[2] = s_axis_tdata[14:10];
  assign cur[3] = s_axis_tdata[19:15];

  // per-hand decode
  assign h0 = hand_decode(prev_q[0], prev_q[1], cur[0], cur[1],
                          growing_q[0], up_first_q[0], 1'b0);
  assign h1 = hand_decode(prev_q[2], prev_q[3], cur[2], cur[3],
                          growing_q[1], up_first_q[1], 1'b1);

  // shift fix-up over both hands
  assign mods_or  = h0.mods | h1.mods;
  assign mods_clr = (h0.clr_shift || h1.clr_shift) ? (mods_or & ~SHIFT_BITS) : mods_or;

  always_comb begin
    prev_d      = prev_q;
    growing_d   = growing_q;
    up_first_d  = up_first_q;
    out_valid_d = out_valid_q;
    mods_d      = mods_q;
    keys_d      = keys_q;
    count_d     = count_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      prev_d      = cur;
      growing_d   = {h1.growing, h0.growing};
      up_first_d  = {h1.up_first, h0.up_first};
      out_valid_d = 1'b1;
      mods_d      = mods_clr;
      if ((h0.set_shift || h1.set_shift) && ((mods_clr & SHIFT_BITS) == '0)) begin
        mods_d = mods_clr | LSHIFT_BIT;
      end
      // pack first-hand keys ahead of second-hand keys
      case (h0.count)
        2'd1:    keys_d = {8'h00, h1.keys[1], h1.keys[0], h0.keys[0]};
        2'd2:    keys_d = {h1.keys[1], h1.keys[0], h0.keys[1], h0.keys[0]};
        default: keys_d = {8'h00, 8'h00, h1.keys[1], h1.keys[0]};
      endcase
      count_d = CountW'(h0.count) + CountW'(h1.count);
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      growing_q   <= '1;
      up_first_q  <= '1;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      growing_q   <= growing_d;
      up_first_q  <= up_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // report payload
  always_ff @(posedge clk_i) begin
    mods_q  <= mods_d;
    keys_q  <= keys_d;
    count_q <= count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, count_q, keys_q[3], keys_q[2], keys_q[1], keys_q[0], mods_q};

endmodule
